### rtl/core/csu_pkg.sv
// Shared types, widths and phase-step tables for the cubic spline upsampler.
// Used by csu_ctrl, csu_datapath and cubic_spline_upsampler; no dependencies.
package csu_pkg;

  localparam int SampleW    = 16;
  localparam int SampleBits = 16;
  localparam int ValueW     = 25;
  localparam int FactorW    = 5;
  localparam int AW         = 19;
  localparam int BW         = 20;
  localparam int CW         = 17;
  localparam int TW         = 16;
  localparam int StepW      = 17;
  localparam int PW         = 37;
  localparam int QW         = 38;
  localparam int RW         = 55;

  localparam logic [FactorW-1:0] FactorReset = 5'd4;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } csu_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last_out;
  } csu_out_t;

  typedef enum logic {
    WIN_INNER = 1'b0,
    WIN_TAIL  = 1'b1
  } csu_win_e;

  typedef struct packed {
    logic     accept;
    logic     load_coef;
    csu_win_e win;
    logic     issue;
    logic     final_pt;
    logic     clear_hist;
  } csu_cmd_t;

  typedef struct packed {
    logic advance;
    logic seen_ge1;
    logic seen_ge2;
    logic seg_end;
    logic factor_zero;
  } csu_stat_t;

  function automatic logic signed [SampleW-1:0] sample_ext(logic [SampleW-1:0] raw);
    logic signed [SampleW-1:0] sh;
    sh = raw << (SampleW - SampleBits);
    return sh >>> (SampleW - SampleBits);
  endfunction

  // floor(65536 / f)
  function automatic logic [StepW-1:0] phase_step(logic [FactorW-1:0] f);
    logic [StepW-1:0] s;
    case (f)
      5'd1:    s = 17'd65536;
      5'd2:    s = 17'd32768;
      5'd3:    s = 17'd21845;
      5'd4:    s = 17'd16384;
      5'd5:    s = 17'd13107;
      5'd6:    s = 17'd10922;
      5'd7:    s = 17'd9362;
      5'd8:    s = 17'd8192;
      5'd9:    s = 17'd7281;
      5'd10:   s = 17'd6553;
      5'd11:   s = 17'd5957;
      5'd12:   s = 17'd5461;
      5'd13:   s = 17'd5041;
      5'd14:   s = 17'd4681;
      5'd15:   s = 17'd4369;
      5'd16:   s = 17'd4096;
      5'd17:   s = 17'd3855;
      5'd18:   s = 17'd3640;
      5'd19:   s = 17'd3449;
      5'd20:   s = 17'd3276;
      5'd21:   s = 17'd3120;
      5'd22:   s = 17'd2978;
      5'd23:   s = 17'd2849;
      5'd24:   s = 17'd2730;
      5'd25:   s = 17'd2621;
      5'd26:   s = 17'd2520;
      5'd27:   s = 17'd2427;
      5'd28:   s = 17'd2340;
      5'd29:   s = 17'd2259;
      5'd30:   s = 17'd2184;
      5'd31:   s = 17'd2114;
      default: s = '0;
    endcase
    return s;
  endfunction

  // 65536 mod f
  function automatic logic [FactorW-1:0] phase_rem(logic [FactorW-1:0] f);
    logic [FactorW-1:0] r;
    case (f)
      5'd3, 5'd5, 5'd15, 5'd17:                  r = 5'd1;
      5'd7, 5'd14, 5'd31:                        r = 5'd2;
      5'd13:                                     r = 5'd3;
      5'd6, 5'd12:                               r = 5'd4;
      5'd19:                                     r = 5'd5;
      5'd10:                                     r = 5'd6;
      5'd9, 5'd27:                               r = 5'd7;
      5'd11, 5'd23:                              r = 5'd9;
      5'd25:                                     r = 5'd11;
      5'd18, 5'd20, 5'd21, 5'd24, 5'd26, 5'd28, 5'd30: r = 5'd16;
      5'd22:                                     r = 5'd20;
      5'd29:                                     r = 5'd25;
      default:                                   r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/csu_ctrl.sv
// Controller for the cubic spline upsampler: sequences segments and the final point.
// Depends on csu_pkg; drives csu_datapath through csu_cmd_t, reads csu_stat_t.
module csu_ctrl import csu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_stall_o,
  input  csu_stat_t stat_i,
  output csu_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN1  = 4'b0010,
    ST_RUN2  = 4'b0100,
    ST_FINAL = 4'b1000
  } csu_state_e;

  csu_state_e state_q, state_d;
  logic       last_q;
  logic       seg_inner;
  logic       seg_tail;

  assign in_stall_o = (state_q != ST_IDLE);
  assign seg_inner  = stat_i.seen_ge2 && !stat_i.factor_zero;
  assign seg_tail   = in_last_i && stat_i.seen_ge1 && !stat_i.factor_zero;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.win = WIN_INNER;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (seg_inner) begin
            cmd_o.load_coef = 1'b1;
            cmd_o.win       = WIN_INNER;
            state_d         = ST_RUN1;
          end else if (seg_tail) begin
            cmd_o.load_coef = 1'b1;
            cmd_o.win       = WIN_TAIL;
            state_d         = ST_RUN2;
          end else if (in_last_i) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_RUN1: begin
        cmd_o.issue = stat_i.advance;
        if (stat_i.advance && stat_i.seg_end) begin
          if (last_q) begin
            cmd_o.load_coef = 1'b1;
            cmd_o.win       = WIN_TAIL;
            state_d         = ST_RUN2;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RUN2: begin
        cmd_o.issue = stat_i.advance;
        if (stat_i.advance && stat_i.seg_end) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd_o.final_pt   = stat_i.advance;
        cmd_o.clear_hist = stat_i.advance;
        if (stat_i.advance) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.accept) begin
        last_q <= in_last_i;
      end
    end
  end

`ifndef SYNTHESIS
  a_run_needs_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN1 || state_q == ST_RUN2) |-> !stat_i.factor_zero)
    else $error("segment running with zero factor");

  a_tail_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN2) |-> last_q)
    else $error("tail segment without last word");

  a_single_goes_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && in_last_i && !stat_i.seen_ge1) |=> (state_q == ST_FINAL))
    else $error("single-sample block did not go to final point");
`endif

endmodule

### rtl/core/csu_datapath.sv
// Datapath of the cubic spline upsampler: history, coefficients, phase stepper,
// four-stage multiply pipeline and output register. Depends on csu_pkg.
module csu_datapath import csu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [FactorW-1:0] cfg_wdata_i,
  input  csu_in_t            in_word_i,
  input  csu_cmd_t           cmd_i,
  output csu_stat_t          stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output csu_out_t           out_word_o
);

  logic [FactorW-1:0]        factor_q;
  logic signed [SampleW-1:0] h0_q, h1_q, h2_q;
  logic [1:0]                seen_q;
  logic signed [SampleW-1:0] s_q;
  logic signed [SampleW-1:0] s_in;
  logic signed [SampleW-1:0] s_cur;

  logic signed [SampleW-1:0] y0, y1, y2, y3;
  logic signed [BW-1:0]      e0, e1, e2, e3;
  logic signed [BW-1:0]      a_full, b_full, c_full;

  logic signed [AW-1:0]      a_q;
  logic signed [BW-1:0]      b_q;
  logic signed [CW-1:0]      c_q;
  logic signed [SampleW-1:0] yc_q;

  logic [StepW-1:0]          t_q, t_d;
  logic [FactorW-1:0]        rem_q, rem_d;
  logic [FactorW-1:0]        j_q;
  logic [FactorW:0]          rem_sum;
  logic                      wrap;

  logic                      advance;

  logic                      s1_valid_q, s1_last_q;
  logic [TW-1:0]             s1_t_q;
  logic signed [AW-1:0]      s1_a_q;
  logic signed [BW-1:0]      s1_b_q;
  logic signed [CW-1:0]      s1_c_q;
  logic signed [SampleW-1:0] s1_y_q;

  logic                      s2_valid_q, s2_last_q;
  logic [TW-1:0]             s2_t_q;
  logic signed [PW-1:0]      s2_p_q, p_d;
  logic signed [CW-1:0]      s2_c_q;
  logic signed [SampleW-1:0] s2_y_q;

  logic                      s3_valid_q, s3_last_q;
  logic [TW-1:0]             s3_t_q;
  logic signed [QW-1:0]      s3_q_q, q_d;
  logic signed [SampleW-1:0] s3_y_q;

  logic                      s4_valid_q, s4_last_q;
  logic signed [RW-1:0]      s4_r_q, r_d;
  logic signed [SampleW-1:0] s4_y_q;

  logic                      out_valid_q;
  csu_out_t                  out_word_q, out_word_d;

  logic signed [35:0]        at_prod;
  logic signed [35:0]        b_shift;
  logic signed [53:0]        pt_prod;
  logic signed [QW-1:0]      pt_hi;
  logic signed [32:0]        c_shift;
  logic signed [RW-1:0]      r_round;
  logic signed [29:0]        r_hi;
  logic signed [23:0]        y_base;
  logic signed [31:0]        sum;

  localparam logic signed [RW-1:0] RoundC = 55'sd16777216;

  assign s_in  = sample_ext(in_word_i.sample);
  assign s_cur = cmd_i.accept ? s_in : s_q;

  always_comb begin
    if (cmd_i.win == WIN_TAIL) begin
      y0 = (seen_q >= 2'd2) ? h1_q : h0_q;
      y1 = h0_q;
      y2 = s_cur;
      y3 = s_cur;
    end else begin
      y0 = (seen_q == 2'd3) ? h2_q : h1_q;
      y1 = h1_q;
      y2 = h0_q;
      y3 = s_cur;
    end
  end

  assign e0 = BW'(y0);
  assign e1 = BW'(y1);
  assign e2 = BW'(y2);
  assign e3 = BW'(y3);
  assign a_full = -e0 + (e1 <<< 1) + e1 - ((e2 <<< 1) + e2) + e3;
  assign b_full = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
  assign c_full = e2 - e0;

  assign advance = !out_valid_q || !out_stall_i;

  assign rem_sum = {1'b0, rem_q} + {1'b0, phase_rem(factor_q)};
  assign wrap    = (rem_sum >= {1'b0, factor_q});
  assign rem_d   = wrap ? FactorW'(rem_sum - {1'b0, factor_q}) : rem_sum[FactorW-1:0];
  assign t_d     = t_q + phase_step(factor_q) + StepW'(wrap);

  assign stat_o.advance     = advance;
  assign stat_o.seen_ge1    = (seen_q != 2'd0);
  assign stat_o.seen_ge2    = (seen_q >= 2'd2);
  assign stat_o.seg_end     = (j_q == factor_q - 5'd1);
  assign stat_o.factor_zero = (factor_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FactorReset;
    end else if (cfg_we_i) begin
      factor_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h0_q   <= '0;
      h1_q   <= '0;
      h2_q   <= '0;
      seen_q <= '0;
    end else if (cmd_i.clear_hist) begin
      h0_q   <= '0;
      h1_q   <= '0;
      h2_q   <= '0;
      seen_q <= '0;
    end else if (cmd_i.accept && !in_word_i.last) begin
      h0_q <= s_in;
      h1_q <= h0_q;
      h2_q <= h1_q;
      if (seen_q != 2'd3) begin
        seen_q <= seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s_q <= s_in;
    end
    if (cmd_i.load_coef) begin
      a_q  <= a_full[AW-1:0];
      b_q  <= b_full;
      c_q  <= c_full[CW-1:0];
      yc_q <= y1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q   <= '0;
      rem_q <= '0;
      j_q   <= '0;
    end else if (cmd_i.load_coef) begin
      t_q   <= '0;
      rem_q <= '0;
      j_q   <= '0;
    end else if (cmd_i.issue) begin
      t_q   <= t_d;
      rem_q <= rem_d;
      j_q   <= j_q + 5'd1;
    end
  end

  assign at_prod = 36'(s1_a_q) * 36'($signed({1'b0, s1_t_q}));
  assign b_shift = {s1_b_q, 16'h0000};
  assign p_d     = PW'(at_prod) + PW'(b_shift);

  assign pt_prod = 54'(s2_p_q) * 54'($signed({1'b0, s2_t_q}));
  assign pt_hi   = pt_prod[53:16];
  assign c_shift = {s2_c_q, 16'h0000};
  assign q_d     = pt_hi + QW'(c_shift);

  assign r_d     = RW'(s3_q_q) * RW'($signed({1'b0, s3_t_q}));

  assign r_round = s4_r_q + RoundC;
  assign r_hi    = r_round[RW-1:25];
  assign y_base  = {s4_y_q, 8'h00};
  assign sum     = 32'(r_hi) + 32'(y_base);

  always_comb begin
    out_word_d.last_out = s4_last_q;
    if (sum[31:24] != {8{sum[31]}}) begin
      out_word_d.value = sum[31] ? {1'b1, 24'h000000} : {1'b0, 24'hFFFFFF};
    end else begin
      out_word_d.value = sum[ValueW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= cmd_i.issue || cmd_i.final_pt;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (cmd_i.final_pt) begin
        s1_t_q    <= '0;
        s1_a_q    <= '0;
        s1_b_q    <= '0;
        s1_c_q    <= '0;
        s1_y_q    <= s_q;
        s1_last_q <= 1'b1;
      end else begin
        s1_t_q    <= t_q[TW-1:0];
        s1_a_q    <= a_q;
        s1_b_q    <= b_q;
        s1_c_q    <= c_q;
        s1_y_q    <= yc_q;
        s1_last_q <= 1'b0;
      end
      s2_t_q     <= s1_t_q;
      s2_p_q     <= p_d;
      s2_c_q     <= s1_c_q;
      s2_y_q     <= s1_y_q;
      s2_last_q  <= s1_last_q;
      s3_t_q     <= s2_t_q;
      s3_q_q     <= q_d;
      s3_y_q     <= s2_y_q;
      s3_last_q  <= s2_last_q;
      s4_r_q     <= r_d;
      s4_y_q     <= s3_y_q;
      s4_last_q  <= s3_last_q;
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (rem_q < factor_q))
    else $error("phase remainder out of range");

  a_phase_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.issue && !stat_o.seg_end) |=> (t_q > $past(t_q)))
    else $error("phase did not advance");

  a_block_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.final_pt |=> (seen_q == 2'd0 && h0_q == '0 && h1_q == '0))
    else $error("history not cleared after final point");
`endif

endmodule

### rtl/core/cubic_spline_upsampler.sv
// Top level of the Catmull-Rom cubic upsampler.
// Depends on csu_pkg, csu_ctrl and csu_datapath.
//
// Usage:
//   Input words (sample, last) enter on in_valid_i / in_stall_o; a word is taken
//   at a clock edge with in_valid_i high and in_stall_o low. Results leave on
//   out_valid_o / out_stall_i as (value, last_out), value in signed Q.8.
//   The points-per-segment factor is written through cfg_we_i / cfg_wdata_i while idle.
// Throughput:
//   The controller issues one interpolated point per cycle, unless a stalled output word
//   holds it, into a four-stage multiply pipeline. An inner sample is accepted and then
//   its segment of factor points is issued; the last sample also brings a tail and final point.
//   Input is stalled while the controller issues points of a segment.
// Pipeline order:
//   Accepting a sample registers its coefficients; each point then passes s1 to s4 and
//   the output register, and the final sample of a block follows its segments.
// Reset and back-pressure:
//   Reset clears history, sample count and pipeline; factor returns to 4.
//   While out_stall_i is high and an output word is valid, the pipeline and the issue of points hold.
module cubic_spline_upsampler import csu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [FactorW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  csu_in_t            in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output csu_out_t           out_word_o
);

  csu_cmd_t  cmd;
  csu_stat_t stat;

  csu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_word_i.last),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  csu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

### test/testbench.sv
// Self-checking testbench for cubic_spline_upsampler: directed table, then random blocks.
// Expected words come from a local Catmull-Rom predictor; depends on csu_pkg and the RTL.
module testbench;
  import csu_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [FactorW-1:0]  cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  csu_in_t             in_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  csu_out_t            out_word_o;

  cubic_spline_upsampler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  typedef struct packed {
    logic                     set_factor;
    logic [FactorW-1:0]       factor;
    logic signed [SampleW-1:0] sample;
    logic                     last;
    logic                     typed;
    logic signed [ValueW-1:0] value;
  } step_row_t;

  localparam int NumRows = 22;
  localparam step_row_t DirRows [NumRows] = '{
    '{1'b0, 5'd0,  16'sh7fff, 1'b1, 1'b1, 25'sd8388352},
    '{1'b0, 5'd0,  16'sh8000, 1'b1, 1'b1, -25'sd8388608},
    '{1'b0, 5'd0,  16'sh0000, 1'b1, 1'b1, 25'sd0},
    '{1'b0, 5'd0,  16'sd100,  1'b0, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  -16'sd200, 1'b1, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  16'sh8000, 1'b0, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  16'sh8000, 1'b0, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  16'sh0000, 1'b1, 1'b0, 25'sd0},
    '{1'b1, 5'd31, 16'sh8000, 1'b0, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  16'sh8000, 1'b1, 1'b0, 25'sd0},
    '{1'b1, 5'd1,  16'sh7fff, 1'b0, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  16'sh8000, 1'b0, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  16'sh5555, 1'b0, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  16'shaaaa, 1'b1, 1'b0, 25'sd0},
    '{1'b1, 5'd0,  16'sd5,    1'b0, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  16'sd6,    1'b0, 1'b0, 25'sd0},
    '{1'b0, 5'd0,  16'sd7,    1'b1, 1'b1, 25'sd1792},
    '{1'b0, 5'd0,  16'shffff, 1'b1, 1'b1, -25'sd256},
    '{1'b1, 5'd31, 16'sh7fff, 1'b1, 1'b1, 25'sd8388352}
  };

  csu_out_t                  points_due [$];
  logic signed [SampleW-1:0] hist [3];
  int                        seen = 0;
  logic [FactorW-1:0]        factor = FactorReset;
  int                        idle_pct = 0;
  int                        stall_pct = 0;
  int                        mismatches = 0;

  initial forever #4 clk_i = ~clk_i;

  initial begin
    #16000000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic signed [ValueW-1:0] clip_value(input longint v);
    if (v > 16777215) return 25'sh0ffffff;
    if (v < -16777216) return 25'sh1000000;
    return v[ValueW-1:0];
  endfunction

  function automatic void push_segment(input longint y0, input longint y1,
                                       input longint y2, input longint y3);
    longint   a, b, c, t, p, q, r;
    int       j;
    csu_out_t pt;
    a = -y0 + 3 * y1 - 3 * y2 + y3;
    b = 2 * y0 - 5 * y1 + 4 * y2 - y3;
    c = y2 - y0;
    for (j = 0; j < int'(factor); j++) begin
      t = (longint'(j) * 65536) / longint'(factor);
      p = a * t + b * 65536;
      q = ((p * t) >>> 16) + c * 65536;
      r = q * t;
      pt.value = clip_value(y1 * 256 + ((r + 16777216) >>> 25));
      pt.last_out = 1'b0;
      points_due.push_back(pt);
    end
  endfunction

  function automatic void spline_predict(input csu_in_t w);
    longint   s;
    csu_out_t tail;
    s = longint'($signed(w.sample));
    if (seen >= 2) push_segment((seen >= 3) ? hist[2] : hist[1], hist[1], hist[0], s);
    if (w.last) begin
      if (seen >= 1) push_segment((seen >= 2) ? hist[1] : hist[0], hist[0], s, s);
      tail.value = clip_value(s * 256);
      tail.last_out = 1'b1;
      points_due.push_back(tail);
      hist[0] = '0;
      hist[1] = '0;
      hist[2] = '0;
      seen = 0;
    end else begin
      hist[2] = hist[1];
      hist[1] = hist[0];
      hist[0] = w.sample;
      if (seen < 3) seen++;
    end
  endfunction

  task automatic send_word(input csu_in_t w, input bit typed,
                           input logic signed [ValueW-1:0] typed_value);
    bit       taken;
    csu_out_t tail;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    forever begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
      if (taken) break;
    end
    spline_predict(w);
    // replace the predicted final word with the value read off by hand
    if (typed) begin
      tail = points_due.pop_back();
      tail.value = typed_value;
      points_due.push_back(tail);
    end
  endtask

  task automatic drain_points(input int settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (points_due.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_factor(input logic [FactorW-1:0] f);
    drain_points(20);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= f;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    factor = f;
  endtask

  function automatic logic [SampleW-1:0] pick_sample(input logic [SampleW-1:0] prev);
    case ($urandom_range(0, 3))
      0:       return SampleW'($urandom);
      1:       return SampleW'($urandom_range(0, 511)) - 16'd256;
      2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return prev + SampleW'($urandom_range(0, 2047)) - 16'd1024;
    endcase
  endfunction

  always @(negedge clk_i) begin
    csu_out_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (points_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word value=%0d last_out=%0b",
                                  out_word_o.value, out_word_o.last_out));
      end else begin
        due = points_due.pop_front();
        if (out_word_o.value !== due.value)
          report_mismatch($sformatf("value %0d, expected %0d",
                                    out_word_o.value, due.value));
        if (out_word_o.last_out !== due.last_out)
          report_mismatch($sformatf("last_out %0b, expected %0b",
                                    out_word_o.last_out, due.last_out));
      end
    end
  end

  initial begin
    csu_in_t            w;
    logic [SampleW-1:0] prev;
    logic [FactorW-1:0] f;
    int                 sent;
    int                 blen;
    int                 pick;
    hist[0] = '0;
    hist[1] = '0;
    hist[2] = '0;
    prev = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stall_pct = 30;
    for (int i = 0; i < NumRows; i++) begin
      if (DirRows[i].set_factor) set_factor(DirRows[i].factor);
      w.sample = DirRows[i].sample;
      w.last   = DirRows[i].last;
      send_word(w, DirRows[i].typed, DirRows[i].value);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       f = 5'd2;
        1:       f = 5'd31;
        2:       f = 5'd1;
        3:       f = 5'd0;
        4:       f = 5'd3;
        5:       f = FactorW'($urandom_range(5, 8));
        6:       f = FactorW'($urandom_range(1, 16));
        default: f = FactorW'($urandom_range(9, 31));
      endcase
      set_factor(f);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      sent = 0;
      while (sent < 50) begin
        pick = $urandom_range(0, 9);
        blen = (pick < 3) ? pick + 1 : $urandom_range(4, 14);
        for (int k = 0; k < blen; k++) begin
          // hold the sender once 30 words of this phase are sent, even mid-block, until every pending word is out
          if (ph == 2 && sent + k == 30) drain_points(0);
          prev = pick_sample(prev);
          w.sample = prev;
          w.last   = (k == blen - 1);
          send_word(w, 1'b0, '0);
        end
        sent += blen;
      end
    end

    drain_points(40);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
